>>> hdl/g2t_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the geodetic to topocentric converter.
// Depends on nothing; g2t_sincos, g2t_fdiv, g2t_rsqrt, g2t_nrad and the top level import it.
package g2t_pkg;

    localparam int ANGLE_BITS_DEF = 32;
    localparam int FRAC_BITS      = 20;
    localparam int OUT_BITS       = 35;
    localparam int TAYLOR_STAGES  = 12;
    localparam int NEWTON_STAGES  = 8;

    localparam logic [63:0] ONE62   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] THREE61 = 64'h6000_0000_0000_0000;
    localparam logic [63:0] PI60    = 64'h3243_F6A8_885A_308D;

    localparam logic [32:0] DEF_MAJOR = 33'd6378245000;
    localparam logic [32:0] DEF_MINOR = 33'd6356863000;

    // Divisors of the Taylor terms: (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
    localparam int unsigned SIN_DIV [TAYLOR_STAGES] =
        '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};
    localparam int unsigned COS_DIV [TAYLOR_STAGES] =
        '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};

    typedef enum logic [2:0] {
        CFG_VIEW_LAT = 3'd0,
        CFG_VIEW_LON = 3'd1,
        CFG_VIEW_HGT = 3'd2,
        CFG_MAJOR    = 3'd3,
        CFG_MINOR    = 3'd4
    } t_cfg_idx;

endpackage

>>> hdl/g2t_in_if.sv
`timescale 1ns / 1ps
// Input channel of the converter: one target point per transfer.
// Depends on nothing.
interface g2t_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target_latitude;
    logic signed [31:0] target_longitude;
    logic signed [27:0] target_height;

    modport source (output valid, target_latitude, target_longitude, target_height,
                    input ready);
    modport sink   (input valid, target_latitude, target_longitude, target_height,
                    output ready);
endinterface

>>> hdl/g2t_out_if.sv
`timescale 1ns / 1ps
// Output channel of the converter: east, north, up and a saturation flag.
// Depends on nothing.
interface g2t_out_if;
    logic               valid;
    logic               ready;
    logic signed [34:0] east_mm;
    logic signed [34:0] north_mm;
    logic signed [34:0] up_mm;
    logic               saturated;

    modport source (output valid, east_mm, north_mm, up_mm, saturated, input ready);
    modport sink   (input valid, east_mm, north_mm, up_mm, saturated, output ready);
endinterface

>>> hdl/g2t_dly.sv
`timescale 1ns / 1ps
// Enabled shift-register delay line for aligning operands in the pipeline.
// Depends on nothing.
module g2t_dly #(
    parameter int W = 64,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sh [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    assign o_q = r_sh[D-1];
endmodule

>>> hdl/g2t_mul.sv
`timescale 1ns / 1ps
// Two-stage unsigned 64x64 multiplier returning 64 bits of (a*b) >> SH.
// Depends on nothing.
module g2t_mul #(
    parameter int SH = 62
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] w_sum;
    logic [63:0]  r_p;

    // Four 32x32 partial products, then one wide add.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= {32'b0, i_a[31:0]}  * {32'b0, i_b[31:0]};
            r_p01 <= {32'b0, i_a[31:0]}  * {32'b0, i_b[63:32]};
            r_p10 <= {32'b0, i_a[63:32]} * {32'b0, i_b[31:0]};
            r_p11 <= {32'b0, i_a[63:32]} * {32'b0, i_b[63:32]};
        end
    end

    assign w_sum = {r_p11, r_p00} + {32'b0, r_p01, 32'b0} + {32'b0, r_p10, 32'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_sum[SH +: 64];
        end
    end

    assign o_p = r_p;
endmodule

>>> hdl/g2t_smul.sv
`timescale 1ns / 1ps
// Signed length times signed Q62, truncated toward zero; four stages.
// Depends on g2t_mul and g2t_dly.
module g2t_smul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    input  logic [63:0] i_s,
    output logic [63:0] o_p
);
    logic [63:0] r_ma, r_mb, w_p, r_p;
    logic        r_neg, w_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= i_x[63] ? 64'(-i_x) : i_x;
            r_mb  <= i_s[63] ? 64'(-i_s) : i_s;
            r_neg <= i_x[63] ^ i_s[63];
        end
    end

    g2t_mul #(.SH(62)) u_mul (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_ma), .i_b(r_mb), .o_p(w_p)
    );

    g2t_dly #(.W(1), .D(2)) u_neg (
        .i_clk(i_clk), .i_en(i_en), .i_d(r_neg), .o_q(w_neg)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_neg ? 64'(-w_p) : w_p;
        end
    end

    assign o_p = r_p;
endmodule

>>> hdl/g2t_divc.sv
`timescale 1ns / 1ps
// Exact 64-bit division by a small constant: reciprocal multiply, then one
// correction step. Three stages. Depends on g2t_mul and g2t_dly.
module g2t_divc #(
    parameter int unsigned D = 6
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    output logic [63:0] o_q
);
    localparam logic [63:0] RECIP = 64'((65'd1 << 64) / D);
    localparam logic [63:0] D64   = 64'(D);

    logic [63:0] w_q0, w_x, w_rem, r_q;

    g2t_mul #(.SH(64)) u_mul (
        .i_clk(i_clk), .i_en(i_en), .i_a(i_x), .i_b(RECIP), .o_p(w_q0)
    );

    g2t_dly #(.W(64), .D(2)) u_x (
        .i_clk(i_clk), .i_en(i_en), .i_d(i_x), .o_q(w_x)
    );

    // The estimate is low by at most one.
    assign w_rem = w_x - 64'(w_q0 * D64);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= (w_rem >= D64) ? w_q0 + 64'd1 : w_q0;
        end
    end

    assign o_q = r_q;
endmodule

>>> hdl/g2t_sincos.sv
`timescale 1ns / 1ps
// Pipelined sine and cosine of a binary angle in signed Q62 (78 stages):
// octant folding, radian scaling, twelve Taylor stages each way.
// Depends on g2t_pkg, g2t_mul, g2t_divc and g2t_dly.
module g2t_sincos
    import g2t_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_angle,
    output logic [63:0] o_sin,
    output logic [63:0] o_cos
);
    localparam int          CUT  = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
    localparam logic [31:0] MASK = ~((32'd1 << CUT) - 32'd1);
    localparam int          FOLD_DLY = 6 * TAYLOR_STAGES + 4;

    logic [31:0] w_u;
    logic [30:0] w_rf;
    logic        w_swap;
    logic [29:0] r_r;
    logic [1:0]  r_quad, w_quad;
    logic        r_swap, w_swap_d;
    logic [63:0] w_t, w_t_d, w_t2;
    logic [63:0] s_term [TAYLOR_STAGES+1];
    logic [63:0] s_acc  [TAYLOR_STAGES+1];
    logic [63:0] c_term [TAYLOR_STAGES+1];
    logic [63:0] c_acc  [TAYLOR_STAGES+1];
    logic [63:0] t2_s   [TAYLOR_STAGES+1];
    logic [63:0] w_s, w_c, r_sin, r_cos;

    // Fold to the first octant by quadrant and complement.
    assign w_u    = i_angle & MASK;
    assign w_swap = w_u[29:0] > 30'h2000_0000;
    assign w_rf   = w_swap ? 31'h4000_0000 - {1'b0, w_u[29:0]} : {1'b0, w_u[29:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r    <= w_rf[29:0];
            r_quad <= w_u[31:30];
            r_swap <= w_swap;
        end
    end

    g2t_mul #(.SH(29)) u_rad (
        .i_clk(i_clk), .i_en(i_en), .i_a({34'b0, r_r}), .i_b(PI60), .o_p(w_t)
    );

    g2t_mul #(.SH(62)) u_sq (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_t), .i_b(w_t), .o_p(w_t2)
    );

    g2t_dly #(.W(64), .D(2)) u_t (
        .i_clk(i_clk), .i_en(i_en), .i_d(w_t), .o_q(w_t_d)
    );

    g2t_dly #(.W(3), .D(FOLD_DLY)) u_fold (
        .i_clk(i_clk), .i_en(i_en), .i_d({r_quad, r_swap}), .o_q({w_quad, w_swap_d})
    );

    assign s_term[0] = w_t_d;
    assign s_acc[0]  = w_t_d;
    assign c_term[0] = ONE62;
    assign c_acc[0]  = ONE62;
    assign t2_s[0]   = w_t2;

    for (genvar k = 1; k <= TAYLOR_STAGES; k++) begin : g_term
        localparam bit ODD = (k % 2) == 1;
        logic [63:0] w_sp, w_sq, w_sa, w_st, r_sa;
        logic [63:0] w_cp, w_cq, w_ca, w_ct, r_ca;

        g2t_mul #(.SH(62)) u_smul (
            .i_clk(i_clk), .i_en(i_en), .i_a(s_term[k-1]), .i_b(t2_s[k-1]), .o_p(w_sp)
        );
        g2t_divc #(.D(SIN_DIV[k-1])) u_sdiv (
            .i_clk(i_clk), .i_en(i_en), .i_x(w_sp), .o_q(w_sq)
        );
        g2t_dly #(.W(64), .D(5)) u_sacc (
            .i_clk(i_clk), .i_en(i_en), .i_d(s_acc[k-1]), .o_q(w_sa)
        );
        g2t_dly #(.W(64), .D(1)) u_sterm (
            .i_clk(i_clk), .i_en(i_en), .i_d(w_sq), .o_q(w_st)
        );

        g2t_mul #(.SH(62)) u_cmul (
            .i_clk(i_clk), .i_en(i_en), .i_a(c_term[k-1]), .i_b(t2_s[k-1]), .o_p(w_cp)
        );
        g2t_divc #(.D(COS_DIV[k-1])) u_cdiv (
            .i_clk(i_clk), .i_en(i_en), .i_x(w_cp), .o_q(w_cq)
        );
        g2t_dly #(.W(64), .D(5)) u_cacc (
            .i_clk(i_clk), .i_en(i_en), .i_d(c_acc[k-1]), .o_q(w_ca)
        );
        g2t_dly #(.W(64), .D(1)) u_cterm (
            .i_clk(i_clk), .i_en(i_en), .i_d(w_cq), .o_q(w_ct)
        );

        g2t_dly #(.W(64), .D(6)) u_t2 (
            .i_clk(i_clk), .i_en(i_en), .i_d(t2_s[k-1]), .o_q(t2_s[k])
        );

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sa <= ODD ? w_sa - w_sq : w_sa + w_sq;
                r_ca <= ODD ? w_ca - w_cq : w_ca + w_cq;
            end
        end

        assign s_term[k] = w_st;
        assign c_term[k] = w_ct;
        assign s_acc[k]  = r_sa;
        assign c_acc[k]  = r_ca;
    end

    assign w_s = w_swap_d ? c_acc[TAYLOR_STAGES] : s_acc[TAYLOR_STAGES];
    assign w_c = w_swap_d ? s_acc[TAYLOR_STAGES] : c_acc[TAYLOR_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (w_quad)
                2'd0: begin
                    r_sin <= w_s;
                    r_cos <= w_c;
                end
                2'd1: begin
                    r_sin <= w_c;
                    r_cos <= 64'(-w_s);
                end
                2'd2: begin
                    r_sin <= 64'(-w_s);
                    r_cos <= 64'(-w_c);
                end
                default: begin
                    r_sin <= 64'(-w_c);
                    r_cos <= w_s;
                end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

>>> hdl/g2t_fdiv.sv
`timescale 1ns / 1ps
// Pipelined restoring division n/d in Q62 for n <= d, one quotient bit per
// stage (63 stages); a zero divisor gives one. Depends on g2t_pkg.
module g2t_fdiv
    import g2t_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [32:0] i_n,
    input  logic [32:0] i_d,
    output logic [63:0] o_q
);
    localparam int STEPS = 63;

    logic [32:0] r_rem [STEPS];
    logic [62:0] r_q   [STEPS];
    logic [32:0] r_d   [STEPS];
    logic        r_z   [STEPS];
    logic [33:0] n_sh  [STEPS];
    logic        n_bit [STEPS];

    always_comb begin
        n_sh[0]  = 34'b0;
        n_bit[0] = 1'b0;
        for (int i = 1; i < STEPS; i++) begin
            n_sh[i]  = {r_rem[i-1], 1'b0};
            n_bit[i] = n_sh[i] >= {1'b0, r_d[i-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (i_n >= i_d) ? i_n - i_d : i_n;
            r_q[0]   <= {62'b0, i_n >= i_d};
            r_d[0]   <= i_d;
            r_z[0]   <= i_d == 33'd0;
            for (int i = 1; i < STEPS; i++) begin
                r_rem[i] <= n_bit[i] ? 33'(n_sh[i] - {1'b0, r_d[i-1]}) : n_sh[i][32:0];
                r_q[i]   <= {r_q[i-1][61:0], n_bit[i]};
                r_d[i]   <= r_d[i-1];
                r_z[i]   <= r_z[i-1];
            end
        end
    end

    assign o_q = r_z[STEPS-1] ? ONE62 : {1'b0, r_q[STEPS-1]};
endmodule

>>> hdl/g2t_rsqrt.sv
`timescale 1ns / 1ps
// Pipelined 1/sqrt(w), w in Q62, result Q61: eight Newton stages, starting
// from one. Depends on g2t_pkg, g2t_mul, g2t_dly.
module g2t_rsqrt
    import g2t_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_w,
    output logic [63:0] o_y
);
    logic [63:0] y_s [NEWTON_STAGES+1];
    logic [63:0] w_s [NEWTON_STAGES+1];

    assign y_s[0] = 64'd1 << 61;
    assign w_s[0] = i_w;

    for (genvar k = 0; k < NEWTON_STAGES; k++) begin : g_newton
        logic [63:0] w_y2, w_w2, w_wy, r_f, w_yd;

        g2t_mul #(.SH(61)) u_y2 (
            .i_clk(i_clk), .i_en(i_en), .i_a(y_s[k]), .i_b(y_s[k]), .o_p(w_y2)
        );
        g2t_dly #(.W(64), .D(2)) u_w2 (
            .i_clk(i_clk), .i_en(i_en), .i_d(w_s[k]), .o_q(w_w2)
        );
        g2t_mul #(.SH(62)) u_wy (
            .i_clk(i_clk), .i_en(i_en), .i_a(w_w2), .i_b(w_y2), .o_p(w_wy)
        );

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f <= THREE61 - w_wy;
            end
        end

        g2t_dly #(.W(64), .D(5)) u_yd (
            .i_clk(i_clk), .i_en(i_en), .i_d(y_s[k]), .o_q(w_yd)
        );
        g2t_mul #(.SH(62)) u_yn (
            .i_clk(i_clk), .i_en(i_en), .i_a(w_yd), .i_b(r_f), .o_p(y_s[k+1])
        );
        g2t_dly #(.W(64), .D(5)) u_wn (
            .i_clk(i_clk), .i_en(i_en), .i_d(w_w2), .o_q(w_s[k+1])
        );
    end

    assign o_y = y_s[NEWTON_STAGES];
endmodule

>>> hdl/g2t_nrad.sv
`timescale 1ns / 1ps
// Prime-vertical radius a/sqrt(1 - e2 sin^2) in 2^-20 mm, 64 stages.
// Depends on g2t_pkg, g2t_mul, g2t_dly and g2t_rsqrt.
module g2t_nrad
    import g2t_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_sin,
    input  logic [63:0] i_e2,
    input  logic [32:0] i_a,
    output logic [63:0] o_n
);
    localparam logic [63:0] W_MIN = 64'd1 << 60;

    logic [63:0] r_s, w_ss, w_e2, w_x, w_w, r_w, w_y;
    logic [32:0] w_a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= i_sin[63] ? 64'(-i_sin) : i_sin;
        end
    end

    g2t_mul #(.SH(62)) u_ss (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_s), .i_b(r_s), .o_p(w_ss)
    );
    g2t_dly #(.W(64), .D(3)) u_e2 (
        .i_clk(i_clk), .i_en(i_en), .i_d(i_e2), .o_q(w_e2)
    );
    g2t_mul #(.SH(62)) u_x (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_e2), .i_b(w_ss), .o_p(w_x)
    );

    // A very flat ellipsoid is held at w = 1/4.
    assign w_w = ONE62 - w_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= (w_w < W_MIN) ? W_MIN : w_w;
        end
    end

    g2t_rsqrt u_rsqrt (
        .i_clk(i_clk), .i_en(i_en), .i_w(r_w), .o_y(w_y)
    );
    g2t_dly #(.W(33), .D(6 + 7 * NEWTON_STAGES)) u_a (
        .i_clk(i_clk), .i_en(i_en), .i_d(i_a), .o_q(w_a)
    );
    g2t_mul #(.SH(61 - FRAC_BITS)) u_n (
        .i_clk(i_clk), .i_en(i_en), .i_a({31'b0, w_a}), .i_b(w_y), .o_p(o_n)
    );
endmodule

>>> hdl/geodetic_to_topocentric.sv
`timescale 1ns / 1ps
// Top level of the geodetic to topocentric (east, north, up) converter.
// Depends on g2t_pkg, the channel interfaces and all g2t_* units.
//
// Each transfer on i_in carries one target point (binary-angle latitude and
// longitude, height in millimetres). Exactly one transfer on o_out follows,
// with east, north and up in millimetres and a flag that is set when any of
// them was clamped to the 35-bit range. The viewpoint and the ellipsoid axes
// are for the user to write through the i_cfg_* port only while no point is
// in flight; the block itself does not enforce this.
// One point is accepted in every cycle while the output is not stalled; that
// figure is set by the fully pipelined Taylor, Newton and restoring-division
// units, each step of which has its own register stages, with every 64-bit
// product split across two stages.
//
// Reset (synchronous, active low) empties the pipeline and loads the
// Krasovsky axes and a zero viewpoint. When the receiver stalls with a result
// waiting in the output register, the whole pipeline holds and i_in.ready
// falls; nothing is lost or repeated, and it resumes as soon as the waiting
// result is taken.
module geodetic_to_topocentric
    import g2t_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    g2t_in_if.sink      i_in,
    g2t_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [32:0] i_cfg_data
);
    localparam int LAT = 163;

    // Configuration registers.
    logic [31:0] r_view_lat, r_view_lon;
    logic [27:0] r_view_hgt;
    logic [32:0] r_major, r_minor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_lat <= '0;
            r_view_lon <= '0;
            r_view_hgt <= '0;
            r_major    <= DEF_MAJOR;
            r_minor    <= DEF_MINOR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_VIEW_LAT: r_view_lat <= i_cfg_data[31:0];
                CFG_VIEW_LON: r_view_lon <= i_cfg_data[31:0];
                CFG_VIEW_HGT: r_view_hgt <= i_cfg_data[27:0];
                CFG_MAJOR:    r_major    <= i_cfg_data;
                CFG_MINOR:    r_minor    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: the whole pipeline advances unless the output
    // register holds a result that the receiver has not taken.
    logic           w_en, w_acc;
    logic [LAT-1:0] r_vld;

    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign w_acc      = i_in.valid && w_en;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    // Capture stage. The configuration travels with the point, so each
    // point sees the registers as they stood when it was accepted.
    logic [31:0] r_lat, r_lon, r_vlat, r_vlon;
    logic [63:0] r_h, r_h0;
    logic [32:0] r_a, r_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lat  <= i_in.target_latitude;
            r_lon  <= i_in.target_longitude;
            r_vlat <= r_view_lat;
            r_vlon <= r_view_lon;
            r_h    <= {{(36 - FRAC_BITS){i_in.target_height[27]}},
                       i_in.target_height, FRAC_BITS'(0)};
            r_h0   <= {{(36 - FRAC_BITS){r_view_hgt[27]}}, r_view_hgt, FRAC_BITS'(0)};
            r_a    <= r_major;
            // A minor axis above the major one is taken equal to it.
            r_b    <= (r_minor > r_major) ? r_major : r_minor;
        end
    end

    // Ellipsoid shape: k = b/a, k2 = k^2, e2 = 1 - k2.
    logic [63:0] w_k, w_k2, r_k2, r_e2;

    g2t_fdiv u_fdiv (
        .i_clk(i_clk), .i_en(w_en), .i_n(r_b), .i_d(r_a), .o_q(w_k)
    );
    g2t_mul #(.SH(62)) u_k2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_k), .i_b(w_k), .o_p(w_k2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k2 <= w_k2;
            r_e2 <= ONE62 - w_k2;
        end
    end

    // Sine and cosine of the four angles.
    logic [63:0] w_sbt, w_cbt, w_slt, w_clt, w_sbv, w_cbv, w_slv, w_clv;

    g2t_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_tlat (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r_lat), .o_sin(w_sbt), .o_cos(w_cbt)
    );
    g2t_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_tlon (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r_lon), .o_sin(w_slt), .o_cos(w_clt)
    );
    g2t_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_vlat (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r_vlat), .o_sin(w_sbv), .o_cos(w_cbv)
    );
    g2t_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_vlon (
        .i_clk(i_clk), .i_en(w_en), .i_angle(r_vlon), .o_sin(w_slv), .o_cos(w_clv)
    );

    // Prime-vertical radii of target and viewpoint.
    logic [63:0] w_e2_79, w_n, w_n0;
    logic [32:0] w_a_79;

    g2t_dly #(.W(64), .D(12)) u_d_e2a (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_e2), .o_q(w_e2_79)
    );
    g2t_dly #(.W(33), .D(78)) u_d_a (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_a), .o_q(w_a_79)
    );
    g2t_nrad u_nrad_t (
        .i_clk(i_clk), .i_en(w_en), .i_sin(w_sbt), .i_e2(w_e2_79), .i_a(w_a_79),
        .o_n(w_n)
    );
    g2t_nrad u_nrad_v (
        .i_clk(i_clk), .i_en(w_en), .i_sin(w_sbv), .i_e2(w_e2_79), .i_a(w_a_79),
        .o_n(w_n0)
    );

    // Alignment of the operands used after the radii are known.
    logic [63:0] w_h143, w_h147, w_h0_143, w_k2_143, w_e2_143;
    logic [63:0] w_cbt144, w_sbt148, w_clt148, w_slt148;
    logic [63:0] w_clv152, w_slv152, w_sbv147, w_sbv157, w_cbv157;

    g2t_dly #(.W(64), .D(142)) u_d_h    (.i_clk(i_clk), .i_en(w_en), .i_d(r_h),
                                         .o_q(w_h143));
    g2t_dly #(.W(64), .D(4))   u_d_h2   (.i_clk(i_clk), .i_en(w_en), .i_d(w_h143),
                                         .o_q(w_h147));
    g2t_dly #(.W(64), .D(142)) u_d_h0   (.i_clk(i_clk), .i_en(w_en), .i_d(r_h0),
                                         .o_q(w_h0_143));
    g2t_dly #(.W(64), .D(76))  u_d_k2   (.i_clk(i_clk), .i_en(w_en), .i_d(r_k2),
                                         .o_q(w_k2_143));
    g2t_dly #(.W(64), .D(64))  u_d_e2b  (.i_clk(i_clk), .i_en(w_en), .i_d(w_e2_79),
                                         .o_q(w_e2_143));
    g2t_dly #(.W(64), .D(65))  u_d_cbt  (.i_clk(i_clk), .i_en(w_en), .i_d(w_cbt),
                                         .o_q(w_cbt144));
    g2t_dly #(.W(64), .D(69))  u_d_sbt  (.i_clk(i_clk), .i_en(w_en), .i_d(w_sbt),
                                         .o_q(w_sbt148));
    g2t_dly #(.W(64), .D(69))  u_d_clt  (.i_clk(i_clk), .i_en(w_en), .i_d(w_clt),
                                         .o_q(w_clt148));
    g2t_dly #(.W(64), .D(69))  u_d_slt  (.i_clk(i_clk), .i_en(w_en), .i_d(w_slt),
                                         .o_q(w_slt148));
    g2t_dly #(.W(64), .D(73))  u_d_clv  (.i_clk(i_clk), .i_en(w_en), .i_d(w_clv),
                                         .o_q(w_clv152));
    g2t_dly #(.W(64), .D(73))  u_d_slv  (.i_clk(i_clk), .i_en(w_en), .i_d(w_slv),
                                         .o_q(w_slv152));
    g2t_dly #(.W(64), .D(68))  u_d_sbv  (.i_clk(i_clk), .i_en(w_en), .i_d(w_sbv),
                                         .o_q(w_sbv147));
    g2t_dly #(.W(64), .D(10))  u_d_sbv2 (.i_clk(i_clk), .i_en(w_en), .i_d(w_sbv147),
                                         .o_q(w_sbv157));
    g2t_dly #(.W(64), .D(78))  u_d_cbv  (.i_clk(i_clk), .i_en(w_en), .i_d(w_cbv),
                                         .o_q(w_cbv157));

    // Earth-centred XYZ of the target.
    logic [63:0] r_nh, r_n0h0, w_nk2, w_n0e2, w_rc, r_zin, w_z, w_zsp, w_zsp152;
    logic [63:0] w_x, w_y;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nh   <= w_n + w_h143;
            r_n0h0 <= w_n0 + w_h0_143;
        end
    end

    g2t_smul u_nk2  (.i_clk(i_clk), .i_en(w_en), .i_x(w_n),  .i_s(w_k2_143), .o_p(w_nk2));
    g2t_smul u_n0e2 (.i_clk(i_clk), .i_en(w_en), .i_x(w_n0), .i_s(w_e2_143), .o_p(w_n0e2));
    g2t_smul u_rc   (.i_clk(i_clk), .i_en(w_en), .i_x(r_nh), .i_s(w_cbt144), .o_p(w_rc));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zin <= w_nk2 + w_h147;
        end
    end

    g2t_smul u_z   (.i_clk(i_clk), .i_en(w_en), .i_x(r_zin),  .i_s(w_sbt148), .o_p(w_z));
    g2t_smul u_zsp (.i_clk(i_clk), .i_en(w_en), .i_x(w_n0e2), .i_s(w_sbv147), .o_p(w_zsp));
    g2t_smul u_x   (.i_clk(i_clk), .i_en(w_en), .i_x(w_rc),   .i_s(w_clt148), .o_p(w_x));
    g2t_smul u_y   (.i_clk(i_clk), .i_en(w_en), .i_x(w_rc),   .i_s(w_slt148), .o_p(w_y));

    g2t_dly #(.W(64), .D(1)) u_d_zsp (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_zsp), .o_q(w_zsp152)
    );

    // Shift to the viewpoint's centre of curvature and rotate by longitude.
    logic [63:0] r_zs, w_zs157, w_xc, w_ys, w_yc, w_xs, r_xr, r_east;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zs <= w_z + w_zsp152;
        end
    end

    g2t_smul u_xc (.i_clk(i_clk), .i_en(w_en), .i_x(w_x), .i_s(w_clv152), .o_p(w_xc));
    g2t_smul u_ys (.i_clk(i_clk), .i_en(w_en), .i_x(w_y), .i_s(w_slv152), .o_p(w_ys));
    g2t_smul u_yc (.i_clk(i_clk), .i_en(w_en), .i_x(w_y), .i_s(w_clv152), .o_p(w_yc));
    g2t_smul u_xs (.i_clk(i_clk), .i_en(w_en), .i_x(w_x), .i_s(w_slv152), .o_p(w_xs));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xr   <= w_xc + w_ys;
            r_east <= w_yc - w_xs;
        end
    end

    g2t_dly #(.W(64), .D(4)) u_d_zs (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_zs), .o_q(w_zs157)
    );

    // Rotate by latitude; up is measured from the viewpoint itself.
    logic [63:0] w_q1, w_q2, w_q3, w_q4, w_n0h0_161, w_east162, r_north, r_up;

    g2t_smul u_q1 (.i_clk(i_clk), .i_en(w_en), .i_x(w_zs157), .i_s(w_cbv157), .o_p(w_q1));
    g2t_smul u_q2 (.i_clk(i_clk), .i_en(w_en), .i_x(r_xr),    .i_s(w_sbv157), .o_p(w_q2));
    g2t_smul u_q3 (.i_clk(i_clk), .i_en(w_en), .i_x(r_xr),    .i_s(w_cbv157), .o_p(w_q3));
    g2t_smul u_q4 (.i_clk(i_clk), .i_en(w_en), .i_x(w_zs157), .i_s(w_sbv157), .o_p(w_q4));

    g2t_dly #(.W(64), .D(17)) u_d_n0h0 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_n0h0), .o_q(w_n0h0_161)
    );
    g2t_dly #(.W(64), .D(5)) u_d_east (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_east), .o_q(w_east162)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_north <= w_q1 - w_q2;
            r_up    <= w_q3 + w_q4 - w_n0h0_161;
        end
    end

    // Round half up to millimetres and clamp to the 35-bit range.
    // Result: {clamped, value}.
    function automatic logic [OUT_BITS:0] f_to_mm(input logic [63:0] v);
        logic [63:0]            rnd;
        logic [63-FRAC_BITS:0]  q;
        logic                   fits;
        rnd  = v + (64'd1 << (FRAC_BITS - 1));
        q    = rnd[63:FRAC_BITS];
        fits = (q[63-FRAC_BITS:OUT_BITS-1] == '0) || (q[63-FRAC_BITS:OUT_BITS-1] == '1);
        if (fits) begin
            f_to_mm = {1'b0, q[OUT_BITS-1:0]};
        end else begin
            f_to_mm = {1'b1, q[63-FRAC_BITS], {(OUT_BITS - 1){!q[63-FRAC_BITS]}}};
        end
    endfunction

    logic [OUT_BITS:0] w_me, w_mn, w_mu;
    logic [OUT_BITS-1:0] r_east_mm, r_north_mm, r_up_mm;
    logic                r_sat;

    assign w_me = f_to_mm(w_east162);
    assign w_mn = f_to_mm(r_north);
    assign w_mu = f_to_mm(r_up);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_east_mm  <= w_me[OUT_BITS-1:0];
            r_north_mm <= w_mn[OUT_BITS-1:0];
            r_up_mm    <= w_mu[OUT_BITS-1:0];
            r_sat      <= w_me[OUT_BITS] | w_mn[OUT_BITS] | w_mu[OUT_BITS];
        end
    end

    assign o_out.valid     = r_vld[LAT-1];
    assign o_out.east_mm   = r_east_mm;
    assign o_out.north_mm  = r_north_mm;
    assign o_out.up_mm     = r_up_mm;
    assign o_out.saturated = r_sat;
endmodule
